### src/timed_actuator_calibration_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timed actuator calibration sequencer
// Two forms of a clocked check: same-cycle implication and next-cycle
// implication. Both are disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef TIMED_ACTUATOR_CALIBRATION_SEQUENCER_ASSERT_SVH
`define TIMED_ACTUATOR_CALIBRATION_SEQUENCER_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define TACS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define TACS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tacs_pkg.sv
// ----------------------------------------------------------------------------
// tacs_pkg
// Types, codes and constants shared by the calibration sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tacs_pkg;

  // time arithmetic width (now_ms is used modulo 2^TIME_BITS)
  localparam int TIME_BITS = 32;
  localparam int TOUT_BITS = 24;
  localparam int HOLD_BITS = 16;
  localparam int CMP_BITS  = (TIME_BITS > TOUT_BITS) ? TIME_BITS : TOUT_BITS;
  localparam int RUN_BITS  = 16;
  localparam int CFG_BITS  = 24;
  localparam int IDX_BITS  = 2;

  // configuration reset values
  localparam logic [TOUT_BITS-1:0] TOTAL_TIMEOUT_RST = TOUT_BITS'(20000);
  localparam logic [HOLD_BITS-1:0] ENABLE_SETTLE_RST = HOLD_BITS'(200);
  localparam logic [HOLD_BITS-1:0] COMMAND_GAP_RST   = HOLD_BITS'(50);
  localparam logic [HOLD_BITS-1:0] POSITION_HOLD_RST = HOLD_BITS'(1000);

  // configuration register indexes
  localparam logic [IDX_BITS-1:0] REG_TOTAL_TIMEOUT = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_ENABLE_SETTLE = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_COMMAND_GAP   = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_POSITION_HOLD = 2'd3;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_ABORT = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_CHECK   = 4'd1,
    PH_SETTLE  = 4'd2,
    PH_ZERO    = 4'd3,
    PH_PARAM   = 4'd4,
    PH_POS     = 4'd5,
    PH_ZERO1   = 4'd6,
    PH_NEG     = 4'd7,
    PH_ZERO2   = 4'd8,
    PH_STOP    = 4'd9,
    PH_DISABLE = 4'd10,
    PH_DONE    = 4'd11,
    PH_FAULT   = 4'd12,
    PH_ABORT   = 4'd13
  } phase_t;

  typedef enum logic [2:0] {
    FLT_NONE     = 3'd0,
    FLT_TIMEOUT  = 3'd1,
    FLT_OFFLINE  = 3'd2,
    FLT_ENABLE   = 3'd3,
    FLT_ZERO     = 3'd4,
    FLT_PARAM    = 3'd5,
    FLT_POSITION = 3'd6
  } fault_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_ENABLE  = 3'd1,
    CMD_ZERO    = 3'd2,
    CMD_PROFILE = 3'd3,
    CMD_MOVE    = 3'd4,
    CMD_STOP    = 3'd5,
    CMD_DISABLE = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    TGT_ZERO = 2'd0,
    TGT_POS  = 2'd1,
    TGT_NEG  = 2'd2
  } target_t;

  // sequencer state carried from item to item
  typedef struct packed {
    phase_t                 phase;
    fault_t                 fault;
    target_t                target;
    logic [RUN_BITS-1:0]    run_count;
    logic [TIME_BITS-1:0]   phase_start;
    logic [TIME_BITS-1:0]   run_start;
    logic                   stop_sent;
    logic                   log_flag;
    logic                   session;
  } seq_state_t;

  // timing configuration
  typedef struct packed {
    logic [TOUT_BITS-1:0] total_timeout;
    logic [HOLD_BITS-1:0] enable_settle;
    logic [HOLD_BITS-1:0] command_gap;
    logic [HOLD_BITS-1:0] position_hold;
  } seq_cfg_t;

  // one input beat
  typedef struct packed {
    action_t              action;
    logic [TIME_BITS-1:0] now;
    logic                 healthy;
    logic                 ok;
  } seq_in_t;

  // one result beat
  typedef struct packed {
    logic                start_accepted;
    phase_t              phase;
    fault_t              fault_code;
    cmd_t                command;
    logic                shutdown_issued;
    logic                session_on;
    target_t             target_dir;
    logic [RUN_BITS-1:0] run_count;
    logic                run_active;
    logic                has_result;
    logic                log_pending;
  } seq_res_t;

endpackage

`default_nettype wire

### src/timed_actuator_calibration_sequencer.sv
// A beat accepted into the input register moves to the result register when that
// register is free, and is offered on the result channel from there.
// The block takes one beat per cycle while the result channel does not stall.
// An input register and a result register part the two channels, so a new beat
// is taken while a finished result still waits on a stalled output.
// Reset (rst, synchronous, active high) returns to idle, clears the run count
// and flags and loads the default timing registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
// timed_actuator_calibration_sequencer
// Top level: input register, sequencer state, timing registers, result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_actuator_calibration_sequencer_assert.svh"

module timed_actuator_calibration_sequencer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       action,
  input  wire logic [31:0]                      now_ms,
  input  wire logic                             actuator_online,
  input  wire logic                             firmware_ok,
  input  wire logic                             closed_loop_ok,
  input  wire logic                             command_ok,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  start_accepted,
  output logic [3:0]                            phase,
  output logic [2:0]                            fault_code,
  output logic [2:0]                            command,
  output logic                                  shutdown_issued,
  output logic                                  session_on,
  output logic [1:0]                            target_dir,
  output logic [15:0]                           run_count,
  output logic                                  run_active,
  output logic                                  has_result,
  output logic                                  log_pending,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [tacs_pkg::IDX_BITS-1:0]    cfg_index,
  input  wire logic [tacs_pkg::CFG_BITS-1:0]    cfg_data
);

  tacs_pkg::seq_in_t    in_q;
  logic                 in_q_valid;
  tacs_pkg::seq_state_t st;
  tacs_pkg::seq_state_t st_next;
  tacs_pkg::seq_cfg_t   cfg;
  tacs_pkg::seq_res_t   res_next;
  tacs_pkg::seq_res_t   res_q;
  logic                 fire;
  logic                 in_take;

  // a beat leaves the input register when the result register is free
  assign fire     = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !fire;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q.action  <= tacs_pkg::action_t'(action);
      in_q.now     <= now_ms[tacs_pkg::TIME_BITS-1:0];
      in_q.healthy <= actuator_online && firmware_ok && closed_loop_ok;
      in_q.ok      <= command_ok;
    end
  end

  // timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_timeout <= tacs_pkg::TOTAL_TIMEOUT_RST;
      cfg.enable_settle <= tacs_pkg::ENABLE_SETTLE_RST;
      cfg.command_gap   <= tacs_pkg::COMMAND_GAP_RST;
      cfg.position_hold <= tacs_pkg::POSITION_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tacs_pkg::REG_TOTAL_TIMEOUT: cfg.total_timeout <= cfg_data[tacs_pkg::TOUT_BITS-1:0];
        tacs_pkg::REG_ENABLE_SETTLE: cfg.enable_settle <= cfg_data[tacs_pkg::HOLD_BITS-1:0];
        tacs_pkg::REG_COMMAND_GAP:   cfg.command_gap   <= cfg_data[tacs_pkg::HOLD_BITS-1:0];
        tacs_pkg::REG_POSITION_HOLD: cfg.position_hold <= cfg_data[tacs_pkg::HOLD_BITS-1:0];
        default: cfg.total_timeout <= cfg.total_timeout;
      endcase
    end
  end

  // sequencer step
  tacs_step u_step (
    .cur  (st),
    .cfg  (cfg),
    .item (in_q),
    .nxt  (st_next),
    .res  (res_next)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= tacs_pkg::PH_IDLE;
      st.fault       <= tacs_pkg::FLT_NONE;
      st.target      <= tacs_pkg::TGT_ZERO;
      st.run_count   <= '0;
      st.phase_start <= '0;
      st.run_start   <= '0;
      st.stop_sent   <= 1'b0;
      st.log_flag    <= 1'b0;
      st.session     <= 1'b0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res_next;
    end
  end

  assign start_accepted  = res_q.start_accepted;
  assign phase           = res_q.phase;
  assign fault_code      = res_q.fault_code;
  assign command         = res_q.command;
  assign shutdown_issued = res_q.shutdown_issued;
  assign session_on      = res_q.session_on;
  assign target_dir      = res_q.target_dir;
  assign run_count       = res_q.run_count;
  assign run_active      = res_q.run_active;
  assign has_result      = res_q.has_result;
  assign log_pending     = res_q.log_pending;

  // checks
  `TACS_ASSERT_NXT(a_hold_stalled_beat, clk, rst, in_q_valid && !fire, in_q_valid,
    "stalled input beat was dropped")
  `TACS_ASSERT_IMP(a_fault_stop_sent, clk, rst, st.phase == tacs_pkg::PH_FAULT,
    st.stop_sent, "fault phase without stop and disable sent")
  `TACS_ASSERT_IMP(a_session_in_run, clk, rst, st.session,
    st.phase >= tacs_pkg::PH_CHECK && st.phase <= tacs_pkg::PH_DISABLE,
    "session held outside an active run")
  `TACS_ASSERT_IMP(a_shutdown_phase, clk, rst, out_valid && shutdown_issued,
    phase == tacs_pkg::PH_FAULT || phase == tacs_pkg::PH_ABORT,
    "shutdown reported outside fault or abort")
  `TACS_ASSERT_IMP(a_active_xor_result, clk, rst, out_valid,
    !(run_active && has_result), "result both active and finished")

endmodule

`default_nettype wire

### src/tacs_step.sv
// ----------------------------------------------------------------------------
// tacs_step
// Next-state and result logic for one beat: start, abort, log read, or a
// tick that checks the run timeout and then the current phase's hold, if it has one.
// ----------------------------------------------------------------------------
`default_nettype none

module tacs_step (
  input  tacs_pkg::seq_state_t cur,
  input  tacs_pkg::seq_cfg_t   cfg,
  input  tacs_pkg::seq_in_t    item,
  output tacs_pkg::seq_state_t nxt,
  output tacs_pkg::seq_res_t   res
);

  logic                               active;
  logic [tacs_pkg::TIME_BITS-1:0]     run_el;
  logic [tacs_pkg::TIME_BITS-1:0]     ph_el;
  logic [tacs_pkg::CMP_BITS-1:0]      run_el_x;
  logic [tacs_pkg::CMP_BITS-1:0]      ph_el_x;
  logic                               timed_out;
  logic                               settle_exp;
  logic                               gap_exp;
  logic                               hold_exp;

  // elapsed times, wrap-safe modulo 2^TIME_BITS
  assign active   = (cur.phase inside {[tacs_pkg::PH_CHECK:tacs_pkg::PH_DISABLE]});
  assign run_el   = item.now - cur.run_start;
  assign ph_el    = item.now - cur.phase_start;
  assign run_el_x = tacs_pkg::CMP_BITS'(run_el);
  assign ph_el_x  = tacs_pkg::CMP_BITS'(ph_el);

  assign timed_out  = run_el_x > tacs_pkg::CMP_BITS'(cfg.total_timeout);
  assign settle_exp = ph_el_x >= tacs_pkg::CMP_BITS'(cfg.enable_settle);
  assign gap_exp    = ph_el_x >= tacs_pkg::CMP_BITS'(cfg.command_gap);
  assign hold_exp   = ph_el_x >= tacs_pkg::CMP_BITS'(cfg.position_hold);

  // sequencing
  always_comb begin
    tacs_pkg::cmd_t      cmd;
    tacs_pkg::fault_t    fcode;
    tacs_pkg::phase_t    adv_phase;
    tacs_pkg::target_t   adv_tgt;
    logic                accepted;
    logic                shut;
    logic                fail;
    logic                adv;
    logic                log_out;

    nxt       = cur;
    cmd       = tacs_pkg::CMD_NONE;
    fcode     = tacs_pkg::FLT_NONE;
    adv_phase = tacs_pkg::PH_IDLE;
    adv_tgt   = cur.target;
    accepted  = 1'b0;
    shut      = 1'b0;
    fail      = 1'b0;
    adv       = 1'b0;

    case (item.action)
      tacs_pkg::ACT_START: begin
        if (!active) begin
          accepted        = 1'b1;
          nxt.run_count   = cur.run_count + 1'b1;
          nxt.fault       = tacs_pkg::FLT_NONE;
          nxt.target      = tacs_pkg::TGT_ZERO;
          nxt.run_start   = item.now;
          nxt.stop_sent   = 1'b0;
          nxt.log_flag    = 1'b0;
          nxt.session     = 1'b1;
          nxt.phase       = tacs_pkg::PH_CHECK;
          nxt.phase_start = item.now;
        end
      end
      tacs_pkg::ACT_ABORT: begin
        if (active) begin
          shut            = 1'b1;
          nxt.session     = 1'b0;
          nxt.target      = tacs_pkg::TGT_ZERO;
          nxt.phase       = tacs_pkg::PH_ABORT;
          nxt.phase_start = item.now;
          nxt.log_flag    = 1'b1;
        end
      end
      tacs_pkg::ACT_TICK: begin
        if (active) begin
          if (timed_out) begin
            fail  = 1'b1;
            fcode = tacs_pkg::FLT_TIMEOUT;
          end else begin
            case (cur.phase)
              tacs_pkg::PH_CHECK: begin
                if (!item.healthy) begin
                  fail  = 1'b1;
                  fcode = tacs_pkg::FLT_OFFLINE;
                end else begin
                  cmd       = tacs_pkg::CMD_ENABLE;
                  fcode     = tacs_pkg::FLT_ENABLE;
                  adv_phase = tacs_pkg::PH_SETTLE;
                  adv       = item.ok;
                  fail      = !item.ok;
                end
              end
              tacs_pkg::PH_SETTLE: begin
                if (settle_exp) begin
                  cmd       = tacs_pkg::CMD_ZERO;
                  fcode     = tacs_pkg::FLT_ZERO;
                  adv_phase = tacs_pkg::PH_ZERO;
                  adv       = item.ok;
                  fail      = !item.ok;
                end
              end
              tacs_pkg::PH_ZERO: begin
                if (gap_exp) begin
                  cmd       = tacs_pkg::CMD_PROFILE;
                  fcode     = tacs_pkg::FLT_PARAM;
                  adv_phase = tacs_pkg::PH_PARAM;
                  adv       = item.ok;
                  fail      = !item.ok;
                end
              end
              tacs_pkg::PH_PARAM: begin
                if (gap_exp) begin
                  cmd       = tacs_pkg::CMD_MOVE;
                  fcode     = tacs_pkg::FLT_POSITION;
                  adv_phase = tacs_pkg::PH_POS;
                  adv_tgt   = tacs_pkg::TGT_POS;
                  adv       = item.ok;
                  fail      = !item.ok;
                end
              end
              tacs_pkg::PH_POS: begin
                if (hold_exp) begin
                  cmd       = tacs_pkg::CMD_MOVE;
                  fcode     = tacs_pkg::FLT_POSITION;
                  adv_phase = tacs_pkg::PH_ZERO1;
                  adv_tgt   = tacs_pkg::TGT_ZERO;
                  adv       = item.ok;
                  fail      = !item.ok;
                end
              end
              tacs_pkg::PH_ZERO1: begin
                if (hold_exp) begin
                  cmd       = tacs_pkg::CMD_MOVE;
                  fcode     = tacs_pkg::FLT_POSITION;
                  adv_phase = tacs_pkg::PH_NEG;
                  adv_tgt   = tacs_pkg::TGT_NEG;
                  adv       = item.ok;
                  fail      = !item.ok;
                end
              end
              tacs_pkg::PH_NEG: begin
                if (hold_exp) begin
                  cmd       = tacs_pkg::CMD_MOVE;
                  fcode     = tacs_pkg::FLT_POSITION;
                  adv_phase = tacs_pkg::PH_ZERO2;
                  adv_tgt   = tacs_pkg::TGT_ZERO;
                  adv       = item.ok;
                  fail      = !item.ok;
                end
              end
              tacs_pkg::PH_ZERO2: begin
                if (hold_exp) begin
                  cmd       = tacs_pkg::CMD_STOP;
                  fcode     = tacs_pkg::FLT_POSITION;
                  adv_phase = tacs_pkg::PH_STOP;
                  adv       = item.ok;
                  fail      = !item.ok;
                end
              end
              tacs_pkg::PH_STOP: begin
                // gap expiry moves on without a command
                if (gap_exp) begin
                  adv_phase = tacs_pkg::PH_DISABLE;
                  adv       = 1'b1;
                end
              end
              tacs_pkg::PH_DISABLE: begin
                cmd       = tacs_pkg::CMD_DISABLE;
                fcode     = tacs_pkg::FLT_ENABLE;
                adv_phase = tacs_pkg::PH_DONE;
                adv_tgt   = tacs_pkg::TGT_ZERO;
                adv       = item.ok;
                fail      = !item.ok;
              end
              default: begin
                adv = 1'b0;
              end
            endcase
          end
        end
      end
      default: begin
        accepted = 1'b0;
      end
    endcase

    // fault entry: stop and disable only once per run
    if (fail) begin
      nxt.fault       = fcode;
      nxt.target      = tacs_pkg::TGT_ZERO;
      if (!cur.stop_sent) begin
        shut          = 1'b1;
        nxt.stop_sent = 1'b1;
      end
      nxt.session     = 1'b0;
      nxt.phase       = tacs_pkg::PH_FAULT;
      nxt.phase_start = item.now;
      nxt.log_flag    = 1'b1;
    end

    // normal phase advance
    if (adv) begin
      nxt.target      = adv_tgt;
      nxt.phase       = adv_phase;
      nxt.phase_start = item.now;
      if (adv_phase == tacs_pkg::PH_DONE) begin
        nxt.session  = 1'b0;
        nxt.log_flag = 1'b1;
      end
    end

    // log read reports the flag, then clears it
    log_out = nxt.log_flag;
    if (item.action == tacs_pkg::ACT_READ) begin
      nxt.log_flag = 1'b0;
    end

    res.start_accepted  = accepted;
    res.phase           = nxt.phase;
    res.fault_code      = nxt.fault;
    res.command         = cmd;
    res.shutdown_issued = shut;
    res.session_on      = nxt.session;
    res.target_dir      = nxt.target;
    res.run_count       = nxt.run_count;
    res.run_active      = (nxt.phase inside {[tacs_pkg::PH_CHECK:tacs_pkg::PH_DISABLE]});
    res.has_result      = (nxt.phase inside {tacs_pkg::PH_DONE, tacs_pkg::PH_FAULT,
                                             tacs_pkg::PH_ABORT});
    res.log_pending     = log_out;
  end

endmodule

`default_nettype wire

### tb/sv/calibration_result_checker.sv
// ----------------------------------------------------------------------------
// calibration_result_checker
// Watches both channels and the timing register port of the calibration
// sequencer. Every accepted input beat is run through a local model of the
// sequencer to build the expected result. Every accepted result beat is
// compared field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module calibration_result_checker (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] now_ms,
  input  logic        actuator_online,
  input  logic        firmware_ok,
  input  logic        closed_loop_ok,
  input  logic        command_ok,
  // result channel
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        start_accepted,
  input  logic [3:0]  phase,
  input  logic [2:0]  fault_code,
  input  logic [2:0]  command,
  input  logic        shutdown_issued,
  input  logic        session_on,
  input  logic [1:0]  target_dir,
  input  logic [15:0] run_count,
  input  logic        run_active,
  input  logic        has_result,
  input  logic        log_pending,
  // timing register port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // status toward the test top
  output int          fail_count,
  output int          backlog
);
  import tacs_pkg::*;

  // local copy of sequencer state and timing
  seq_state_t st;
  seq_cfg_t   timing;
  seq_res_t   expected_results[$];

  // per-beat side outputs of the model
  cmd_t cmd_now;
  logic shut_now;

  function automatic bit run_live();
    return (st.phase >= PH_CHECK) && (st.phase <= PH_DISABLE);
  endfunction

  // wrap-safe hold test, greater or equal
  function automatic bit held(logic [31:0] now, logic [15:0] hold);
    logic [31:0] elapsed;
    elapsed = now - st.phase_start;
    return elapsed >= {16'd0, hold};
  endfunction

  function automatic void move_to(phase_t p, logic [31:0] now);
    st.phase       = p;
    st.phase_start = now;
    if (p inside {PH_DONE, PH_FAULT, PH_ABORT}) st.log_flag = 1'b1;
  endfunction

  // stop and disable go out only on the first fault of a run
  function automatic void enter_fault(fault_t f, logic [31:0] now);
    st.fault  = f;
    st.target = TGT_ZERO;
    if (!st.stop_sent) begin
      shut_now     = 1'b1;
      st.stop_sent = 1'b1;
    end
    st.session = 1'b0;
    move_to(PH_FAULT, now);
  endfunction

  // command is reported even when it fails
  function automatic void send_cmd(cmd_t c, logic ok, phase_t nxt, target_t t,
                                   fault_t f, logic [31:0] now);
    cmd_now = c;
    if (!ok) begin
      enter_fault(f, now);
    end else begin
      st.target = t;
      move_to(nxt, now);
    end
  endfunction

  // advance the sequencer model by one input beat, return the result beat
  function automatic seq_res_t step_sequencer(action_t act, logic [31:0] now,
                                              logic healthy, logic ok);
    seq_res_t    r;
    logic        accepted;
    logic        log_seen;
    logic [31:0] run_elapsed;
    accepted    = 1'b0;
    cmd_now     = CMD_NONE;
    shut_now    = 1'b0;
    run_elapsed = now - st.run_start;
    case (act)
      ACT_START: begin
        if (!run_live()) begin
          accepted     = 1'b1;
          st.run_count = st.run_count + 16'd1;
          st.fault     = FLT_NONE;
          st.target    = TGT_ZERO;
          st.run_start = now;
          st.stop_sent = 1'b0;
          st.log_flag  = 1'b0;
          st.session   = 1'b1;
          move_to(PH_CHECK, now);
        end
      end
      ACT_ABORT: begin
        if (run_live()) begin
          shut_now   = 1'b1;
          st.session = 1'b0;
          st.target  = TGT_ZERO;
          move_to(PH_ABORT, now);
        end
      end
      ACT_TICK: begin
        if (run_live()) begin
          // overall timeout wins over any phase hold
          if (run_elapsed > {8'd0, timing.total_timeout}) begin
            enter_fault(FLT_TIMEOUT, now);
          end else begin
            case (st.phase)
              PH_CHECK: begin
                if (!healthy) enter_fault(FLT_OFFLINE, now);
                else send_cmd(CMD_ENABLE, ok, PH_SETTLE, st.target, FLT_ENABLE, now);
              end
              PH_SETTLE: begin
                if (held(now, timing.enable_settle))
                  send_cmd(CMD_ZERO, ok, PH_ZERO, st.target, FLT_ZERO, now);
              end
              PH_ZERO: begin
                if (held(now, timing.command_gap))
                  send_cmd(CMD_PROFILE, ok, PH_PARAM, st.target, FLT_PARAM, now);
              end
              PH_PARAM: begin
                if (held(now, timing.command_gap))
                  send_cmd(CMD_MOVE, ok, PH_POS, TGT_POS, FLT_POSITION, now);
              end
              PH_POS: begin
                if (held(now, timing.position_hold))
                  send_cmd(CMD_MOVE, ok, PH_ZERO1, TGT_ZERO, FLT_POSITION, now);
              end
              PH_ZERO1: begin
                if (held(now, timing.position_hold))
                  send_cmd(CMD_MOVE, ok, PH_NEG, TGT_NEG, FLT_POSITION, now);
              end
              PH_NEG: begin
                if (held(now, timing.position_hold))
                  send_cmd(CMD_MOVE, ok, PH_ZERO2, TGT_ZERO, FLT_POSITION, now);
              end
              PH_ZERO2: begin
                if (held(now, timing.position_hold))
                  send_cmd(CMD_STOP, ok, PH_STOP, st.target, FLT_POSITION, now);
              end
              // stop gap ends with no command
              PH_STOP: begin
                if (held(now, timing.command_gap)) move_to(PH_DISABLE, now);
              end
              PH_DISABLE: begin
                cmd_now = CMD_DISABLE;
                if (!ok) begin
                  enter_fault(FLT_ENABLE, now);
                end else begin
                  st.target  = TGT_ZERO;
                  st.session = 1'b0;
                  move_to(PH_DONE, now);
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase

    // read returns the flag as it was, then clears it
    log_seen = st.log_flag;
    if (act == ACT_READ) st.log_flag = 1'b0;

    r.start_accepted  = accepted;
    r.phase           = st.phase;
    r.fault_code      = st.fault;
    r.command         = cmd_now;
    r.shutdown_issued = shut_now;
    r.session_on      = st.session;
    r.target_dir      = st.target;
    r.run_count       = st.run_count;
    r.run_active      = run_live();
    r.has_result      = st.phase inside {PH_DONE, PH_FAULT, PH_ABORT};
    r.log_pending     = log_seen;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // sample both channels at each rising edge
  always @(posedge clk) begin
    seq_res_t want;
    if (rst) begin
      st                   = '0;
      timing.total_timeout = TOTAL_TIMEOUT_RST;
      timing.enable_settle = ENABLE_SETTLE_RST;
      timing.command_gap   = COMMAND_GAP_RST;
      timing.position_hold = POSITION_HOLD_RST;
      expected_results.delete();
      fail_count = 0;
    end else begin
      // result beat against oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat arrived with no expected result waiting");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("start_accepted", 32'(want.start_accepted), 32'(start_accepted));
          check_field("phase", 32'(want.phase), 32'(phase));
          check_field("fault_code", 32'(want.fault_code), 32'(fault_code));
          check_field("command", 32'(want.command), 32'(command));
          check_field("shutdown_issued", 32'(want.shutdown_issued), 32'(shutdown_issued));
          check_field("session_on", 32'(want.session_on), 32'(session_on));
          check_field("target_dir", 32'(want.target_dir), 32'(target_dir));
          check_field("run_count", 32'(want.run_count), 32'(run_count));
          check_field("run_active", 32'(want.run_active), 32'(run_active));
          check_field("has_result", 32'(want.has_result), 32'(has_result));
          check_field("log_pending", 32'(want.log_pending), 32'(log_pending));
        end
      end
      // timing register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_TOTAL_TIMEOUT: timing.total_timeout = cfg_data;
          REG_ENABLE_SETTLE: timing.enable_settle = cfg_data[15:0];
          REG_COMMAND_GAP:   timing.command_gap   = cfg_data[15:0];
          REG_POSITION_HOLD: timing.position_hold = cfg_data[15:0];
          default: ;
        endcase
      end
      // input beat
      if (in_valid && !in_stall)
        expected_results.push_back(step_sequencer(action_t'(action), now_ms,
          actuator_online & firmware_ok & closed_loop_ok, command_ok));
    end
    backlog = expected_results.size();
  end

endmodule

### tb/sv/timed_actuator_calibration_sequencer_test.sv
// ----------------------------------------------------------------------------
// timed_actuator_calibration_sequencer_test
// Drives the calibration sequencer with a short directed sequence and then
// with random calibration runs under several timing settings, with random
// idling on both channels and two long result hold-offs. Checking is done by
// the result checker instantiated beside the block.
// ----------------------------------------------------------------------------
module timed_actuator_calibration_sequencer_test;
  import tacs_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int N_SETTINGS   = 7;
  localparam int LONG_HOLD    = 80;
  localparam int RUN_TICK_CAP = 40;

  logic        clk             = 1'b0;
  logic        rst             = 1'b1;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [1:0]  action          = ACT_TICK;
  logic [31:0] now_ms          = '0;
  logic        actuator_online = 1'b0;
  logic        firmware_ok     = 1'b0;
  logic        closed_loop_ok  = 1'b0;
  logic        command_ok      = 1'b0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic        start_accepted;
  logic [3:0]  phase;
  logic [2:0]  fault_code;
  logic [2:0]  command;
  logic        shutdown_issued;
  logic        session_on;
  logic [1:0]  target_dir;
  logic [15:0] run_count;
  logic        run_active;
  logic        has_result;
  logic        log_pending;
  logic        cfg_we          = 1'b0;
  logic [1:0]  cfg_index       = REG_TOTAL_TIMEOUT;
  logic [23:0] cfg_data        = '0;
  int          fail_count;
  int          backlog;

  // stimulus shaping state
  logic [31:0] clock_ms   = '0;
  logic [31:0] t_tot      = 32'(TOTAL_TIMEOUT_RST);
  logic [31:0] t_settle   = 32'(ENABLE_SETTLE_RST);
  logic [31:0] t_gap      = 32'(COMMAND_GAP_RST);
  logic [31:0] t_hold     = 32'(POSITION_HOLD_RST);
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  bit          hold_req   = 1'b0;
  int          useful     = 0;
  logic        last_done  = 1'b0;
  logic [15:0] last_run   = '0;

  timed_actuator_calibration_sequencer u_dut (.*);

  calibration_result_checker u_checker (.*);

  always #2 clk = ~clk;

  // end of run guard
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // most gaps short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // time step biased toward the programmed holds
  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 11))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return t_gap - 32'd1;
      3, 4:    return t_gap;
      5:       return t_settle;
      6:       return t_hold - 32'd1;
      7, 8:    return t_hold;
      9:       return t_hold + $urandom_range(1, 3);
      10:      return $urandom_range(0, 2 * t_hold + 2);
      default: return ($urandom_range(0, 7) == 0) ? t_tot + 32'd1 : t_gap + 32'd1;
    endcase
  endfunction

  function automatic logic [2:0] pick_health();
    return ($urandom_range(0, 9) != 0) ? 3'b111 : 3'($urandom);
  endfunction

  // last accepted result, used only to end a run early
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      last_done <= has_result;
      last_run  <= run_count;
    end
  end

  // result side: random stalls plus the requested long hold-off
  initial begin : result_sink
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = LONG_HOLD;
      end else if (rx_gaps_on) begin
        n = pick_gap();
      end else begin
        n = 0;
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // offer one beat, hold it until taken, then maybe idle
  task automatic send_beat(action_t a, logic [31:0] t, logic [2:0] health, logic ok);
    int gap;
    action          <= a;
    now_ms          <= t;
    actuator_online <= health[2];
    firmware_ok     <= health[1];
    closed_loop_ok  <= health[0];
    command_ok      <= ok;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic tick();
    clock_ms = clock_ms + pick_step();
    send_beat(ACT_TICK, clock_ms, pick_health(), $urandom_range(0, 24) != 0);
  endtask

  // drain, then load all four timing registers
  task automatic program_timing(logic [23:0] tot, logic [15:0] settle,
                                logic [15:0] gap, logic [15:0] hold);
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TOTAL_TIMEOUT;
    cfg_data  <= tot;
    @(posedge clk);
    cfg_index <= REG_ENABLE_SETTLE;
    cfg_data  <= {8'($urandom), settle};
    @(posedge clk);
    cfg_index <= REG_COMMAND_GAP;
    cfg_data  <= {8'($urandom), gap};
    @(posedge clk);
    cfg_index <= REG_POSITION_HOLD;
    cfg_data  <= {8'($urandom), hold};
    @(posedge clk);
    cfg_we   <= 1'b0;
    t_tot    = 32'(tot);
    t_settle = 32'(settle);
    t_gap    = 32'(gap);
    t_hold   = 32'(hold);
  endtask

  // one start, then mostly ticks until the run is seen to finish or the tick cap is hit
  task automatic calibration_run();
    logic [15:0] prev;
    int          n;
    int          r;
    r = $urandom_range(0, 9);
    if (r == 0) clock_ms = $urandom;
    else if (r == 1) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * t_hold + 4);
    prev = last_run;
    send_beat(ACT_START, clock_ms, pick_health(), 1'($urandom));
    useful++;
    n = 0;
    while (n < RUN_TICK_CAP && !(last_done && last_run == prev + 16'd1)) begin
      r = $urandom_range(0, 99);
      if (r < 2) send_beat(ACT_START, clock_ms, pick_health(), 1'($urandom));
      else if (r < 4) send_beat(ACT_ABORT, clock_ms, pick_health(), 1'($urandom));
      else if (r < 8) send_beat(ACT_READ, clock_ms, pick_health(), 1'($urandom));
      else tick();
      n++;
      useful++;
    end
    send_beat(ACT_READ, clock_ms, pick_health(), 1'($urandom));
    useful++;
  endtask

  // fully random beats between runs
  task automatic noise_beats();
    repeat ($urandom_range(1, 3))
      send_beat(action_t'($urandom_range(0, 3)), $urandom, 3'($urandom), 1'($urandom));
  endtask

  initial begin : stimulus
    logic [31:0] t0;
    int          s;
    t0 = 32'hFFFF_FF80;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset timing
    send_beat(ACT_TICK, 32'd0, 3'b000, 1'b0);             // tick while idle
    send_beat(ACT_ABORT, 32'd0, 3'b111, 1'b1);            // abort while idle
    send_beat(ACT_READ, 32'd0, 3'b111, 1'b1);             // empty log
    send_beat(ACT_START, t0, 3'b111, 1'b1);
    send_beat(ACT_START, t0 + 32'd5, 3'b111, 1'b1);       // start while active
    send_beat(ACT_TICK, t0 + 32'd10, 3'b101, 1'b1);       // failed precheck
    send_beat(ACT_READ, t0 + 32'd10, 3'b111, 1'b1);
    send_beat(ACT_READ, t0 + 32'd10, 3'b111, 1'b1);
    send_beat(ACT_START, t0 + 32'd20, 3'b111, 1'b1);
    send_beat(ACT_TICK, t0 + 32'd21, 3'b111, 1'b0);       // enable fails
    send_beat(ACT_START, t0 + 32'd30, 3'b111, 1'b1);
    send_beat(ACT_TICK, t0 + 32'd30, 3'b111, 1'b1);
    send_beat(ACT_TICK, t0 + 32'd229, 3'b111, 1'b1);      // one short of settle
    send_beat(ACT_TICK, t0 + 32'd230, 3'b111, 1'b0);      // settle across wrap, zero fails
    send_beat(ACT_START, t0 + 32'd300, 3'b111, 1'b1);
    send_beat(ACT_TICK, t0 + 32'd300, 3'b111, 1'b1);
    send_beat(ACT_ABORT, t0 + 32'd310, 3'b111, 1'b1);
    send_beat(ACT_ABORT, t0 + 32'd320, 3'b111, 1'b1);     // abort after abort
    send_beat(ACT_TICK, t0 + 32'd330, 3'b111, 1'b1);      // tick while aborted
    send_beat(ACT_START, t0 + 32'd400, 3'b111, 1'b1);
    send_beat(ACT_TICK, t0 + 32'd20400, 3'b111, 1'b1);    // timeout limit exactly
    send_beat(ACT_TICK, t0 + 32'd20401, 3'b111, 1'b1);    // timeout exceeded
    send_beat(ACT_START, 32'hFFFF_FFFF, 3'b111, 1'b1);
    send_beat(ACT_TICK, 32'hFFFF_FFFF, 3'b110, 1'b1);     // closed loop missing
    send_beat(ACT_READ, 32'hFFFF_FFFF, 3'b111, 1'b1);
    clock_ms = 32'h0000_1000;

    // random runs under several timing settings
    for (s = 0; s < N_SETTINGS; s++) begin
      case (s)
        0: program_timing(24'd0, 16'd0, 16'd0, 16'd0);
        1: program_timing(24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: program_timing(24'd3000, 16'd5, 16'd3, 16'd8);
        3: program_timing(TOTAL_TIMEOUT_RST, ENABLE_SETTLE_RST, COMMAND_GAP_RST,
                          POSITION_HOLD_RST);
        default: program_timing(24'($urandom_range(40, 600)), 16'($urandom_range(0, 40)),
                                16'($urandom_range(0, 20)), 16'($urandom_range(0, 40)));
      endcase
      // result side holds off while the sender keeps offering
      if (s == 2 || s == 5) begin
        tx_gaps_on = 1'b0;
        hold_req   = 1'b1;
        calibration_run();
      end
      while (useful < (s + 1) * RANDOM_ITEMS / N_SETTINGS) begin
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        rx_gaps_on = ($urandom_range(0, 3) != 0);
        calibration_run();
        if ($urandom_range(0, 9) == 0) noise_beats();
      end
    end

    // drain and give the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && backlog == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/tacs_pkg.sv
src/tacs_step.sv
src/timed_actuator_calibration_sequencer.sv
tb/sv/calibration_result_checker.sv
tb/sv/timed_actuator_calibration_sequencer_test.sv
